// ----- sv/nau_pkg.sv -----
// Shared types, constants and tables for the neural activation unit.
// Depends on nothing; imported by every module of the unit.
`timescale 1ns / 1ps

package nau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    // magnitude of a DATA_WIDTH signed value, including the most negative one
    localparam int MAG_W      = DATA_WIDTH + 1;
    // tanh magnitude, unsigned Q1.16 (65536 = 1.0)
    localparam int TANH_W     = 17;
    // sigmoid, unsigned Q1.17
    localparam int SIG_W      = 18;
    localparam int TBL_IDX_W  = 6;
    localparam int TBL_LAST   = 32;

    // softsign divider: Q0.30 quotient, three quotient bits per stage
    localparam int QUOT_W     = 30;
    localparam int DEN_W      = 16;
    localparam int DIV_STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES = QUOT_W / DIV_STEPS_PER_STAGE;
    localparam int TANH_STAGES = 2;

    localparam int PROD_W     = 2 * QUOT_W + 1;

    // right shifts that bring each intermediate format to FRAC_BITS
    localparam int SH_TANH     = 16 - FRAC_BITS;
    localparam int SH_SIGMOID  = 17 - FRAC_BITS;
    localparam int SH_SOFTSIGN = 30 - FRAC_BITS;
    localparam int SH_GATED    = 33 - FRAC_BITS;
    localparam int SH_SOFTGATE = 60 - FRAC_BITS;

    typedef enum logic [2:0] {
        FUNC_TANH      = 3'd0,
        FUNC_SIGMOID   = 3'd1,
        FUNC_RELU      = 3'd2,
        FUNC_SOFTSIGN  = 3'd3,
        FUNC_LINEAR    = 3'd4,
        FUNC_GATED     = 3'd5,
        FUNC_SOFTGATED = 3'd6
    } func_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value_in;
        logic signed [DATA_WIDTH-1:0] gate_in;
        logic                         last_in;
    } nau_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value_out;
        logic                         last_out;
    } nau_out_t;

    // tanh(k/4), k = 0..32, unsigned Q1.16
    function automatic logic [TANH_W-1:0] tanh_tbl(input logic [TBL_IDX_W-1:0] idx);
        logic [TANH_W-1:0] v;
        case (idx)
            6'd0:  v = 17'd0;
            6'd1:  v = 17'd16051;
            6'd2:  v = 17'd30285;
            6'd3:  v = 17'd41625;
            6'd4:  v = 17'd49912;
            6'd5:  v = 17'd55593;
            6'd6:  v = 17'd59320;
            6'd7:  v = 17'd61694;
            6'd8:  v = 17'd63179;
            6'd9:  v = 17'd64096;
            6'd10: v = 17'd64659;
            6'd11: v = 17'd65003;
            6'd12: v = 17'd65212;
            6'd13: v = 17'd65339;
            6'd14: v = 17'd65417;
            6'd15: v = 17'd65464;
            6'd16: v = 17'd65492;
            6'd17: v = 17'd65509;
            6'd18: v = 17'd65520;
            6'd19: v = 17'd65526;
            6'd20: v = 17'd65530;
            6'd21: v = 17'd65532;
            6'd22: v = 17'd65534;
            6'd23: v = 17'd65535;
            6'd24: v = 17'd65535;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // one restoring-division step: returns {quotient bit, new remainder}
    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                                 input logic [DEN_W-1:0] den,
                                                 input logic             bit_in);
        logic [DEN_W:0] sh;
        logic [DEN_W:0] res;
        sh = {rem, bit_in};
        if (sh >= {1'b0, den})
            res = {1'b1, DEN_W'(sh - {1'b0, den})};
        else
            res = {1'b0, sh[DEN_W-1:0]};
        return res;
    endfunction

endpackage

// ----- sv/nau_tanh_interp.sv -----
// Two-stage tanh of a magnitude: table lookup, then linear interpolation.
// Depends on nau_pkg (table and widths).
`timescale 1ns / 1ps

module nau_tanh_interp #(
    parameter int SHIFT = 10
) (
    input  logic                       clk,
    input  logic                       ce,
    input  logic [nau_pkg::MAG_W-1:0]  mag,
    output logic [nau_pkg::TANH_W-1:0] y
);
    import nau_pkg::*;

    logic [MAG_W-1:0]     idx_full;
    logic [TBL_IDX_W-1:0] idx;
    logic [TANH_W-1:0]    lo_next;
    logic [TANH_W-1:0]    diff_next;
    logic [TANH_W-1:0]    lo_reg;
    logic [TANH_W-1:0]    diff_reg;
    logic [SHIFT-1:0]     frac_reg;
    logic [TANH_W+SHIFT-1:0] prod;
    logic [TANH_W-1:0]    y_next;
    logic [TANH_W-1:0]    y_reg;

    always_comb
    begin
        idx_full = mag >> SHIFT;
        // beyond the last entry the table is flat at 1.0
        if (idx_full >= MAG_W'(TBL_LAST))
            idx = TBL_IDX_W'(TBL_LAST);
        else
            idx = idx_full[TBL_IDX_W-1:0];
        lo_next   = tanh_tbl(idx);
        diff_next = tanh_tbl(TBL_IDX_W'(idx + 1'b1)) - lo_next;
    end

    always_comb
    begin
        prod   = (TANH_W+SHIFT)'(diff_reg) * (TANH_W+SHIFT)'(frac_reg);
        y_next = lo_reg + TANH_W'(prod >> SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            lo_reg   <= lo_next;
            diff_reg <= diff_next;
            frac_reg <= mag[SHIFT-1:0];
            y_reg    <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ----- sv/nau_softsign_div.sv -----
// Pipelined restoring divider for softsign: |x| * 2^30 / (1.0 + |x|), rounded.
// Depends on nau_pkg (div_step, widths, stage count).
`timescale 1ns / 1ps

module nau_softsign_div (
    input  logic                       clk,
    input  logic                       ce,
    input  logic [nau_pkg::MAG_W-1:0]  mag,
    output logic [nau_pkg::QUOT_W-1:0] quot
);
    import nau_pkg::*;

    logic [DEN_W-1:0]  rem_reg [DIV_STAGES];
    logic [DEN_W-1:0]  den_reg [DIV_STAGES];
    logic [QUOT_W-1:0] q_reg   [DIV_STAGES];
    logic [DEN_W-1:0]  rem0;
    logic [DEN_W-1:0]  den0;

    // numerator is mag * 2^30 + den/2; top part (mag) is already below den
    always_comb
    begin
        den0 = DEN_W'((MAG_W'(1) << FRAC_BITS) + mag);
        rem0 = mag[DEN_W-1:0];
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUOT_W-1:0] q_in;
        logic [DEN_W-1:0]  rem_next;
        logic [QUOT_W-1:0] q_next;

        if (k == 0)
        begin : g_first
            assign rem_in = rem0;
            assign den_in = den0;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb
        begin
            logic [QUOT_W-1:0] low;
            logic [DEN_W:0]    res;
            low      = QUOT_W'(den_in[DEN_W-1:1]);
            rem_next = rem_in;
            q_next   = q_in;
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++)
            begin
                res      = div_step(rem_next, den_in,
                                    low[QUOT_W-1-(k*DIV_STEPS_PER_STAGE+j)]);
                rem_next = res[DEN_W-1:0];
                q_next   = {q_next[QUOT_W-2:0], res[DEN_W]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                q_reg[k]   <= q_next;
            end
        end
    end

    assign quot = q_reg[DIV_STAGES-1];

endmodule

// ----- sv/neural_activation_unit.sv -----
// Top level of the neural activation unit: input stage, tanh and softsign
// units, alignment delays, product stage and rounding/saturation stage.
// Depends on nau_pkg, nau_tanh_interp and nau_softsign_div.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid / in_stall / in_word (value, gate, end-of-frame).
//   Output channel: out_valid / out_stall / out_word (result, end-of-frame).
//   function_select_we writes function_select_data into the 3-bit function
//   register (0 tanh, 1 sigmoid, 2 relu, 3 softsign, 4 linear, 5 gated,
//   6 softgated; 7 acts as linear). Write it only while the unit is empty.
//   Throughput: one word per cycle while the receiver does not stall.
//   Depth: the input stage, then the softsign divider, which resolves three
//   quotient bits per stage over ten stages, then the product and rounding
//   stages; the rounding stage holds the result in the output register.
//   All functions go through the same pipe, so ordering is preserved.
//   Stall: the whole pipe freezes while the output register holds a word
//   the receiver stalls; in_stall is raised in those cycles and nothing is
//   dropped or repeated. Bubbles move through with their cleared valid bits.
//   Reset: all valid bits clear and the function register goes to linear.
module neural_activation_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             function_select_we,
    input  logic [2:0]       function_select_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  nau_pkg::nau_in_t in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output nau_pkg::nau_out_t out_word
);
    import nau_pkg::*;

    localparam int TDEL = DIV_STAGES - TANH_STAGES;

    typedef struct packed {
        logic [2:0]       func;
        logic             sx;
        logic             sg;
        logic             sig_neg;
        logic [MAG_W-1:0] mx;
        logic             last;
    } side_t;

    typedef struct packed {
        logic [TANH_W-1:0] ya;
        logic [SIG_W-1:0]  sig;
    } tanh_t;

    logic             ce;
    logic [2:0]       func_reg;

    // input stage
    logic             s1_valid_reg;
    nau_in_t          s1_word_reg;
    logic [2:0]       s1_func_reg;

    logic [MAG_W-1:0] xe;
    logic [MAG_W-1:0] ge;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_g;
    logic [MAG_W-1:0] mag_sig;
    logic             sig_neg;

    logic [TANH_W-1:0] ya;
    logic [TANH_W-1:0] yb;
    logic [QUOT_W-1:0] qx;
    logic [QUOT_W-1:0] qg;

    side_t            side_next;
    side_t            side_reg  [DIV_STAGES];
    logic             side_valid_reg [DIV_STAGES];
    tanh_t            tdel_next;
    tanh_t            tdel_reg  [TDEL];

    // product stage
    logic              p_valid_reg;
    logic [PROD_W-1:0] p_mag_reg;
    logic              p_neg_reg;
    logic [2:0]        p_func_reg;
    logic              p_last_reg;
    logic [PROD_W-1:0] p_mag_next;
    logic              p_neg_next;

    // rounding stage
    logic [PROD_W-1:0] r_mag;
    logic [PROD_W-1:0] r_lim;
    logic [DATA_WIDTH:0] r_signed;
    logic              out_valid_reg;
    nau_out_t          out_word_reg;
    nau_out_t          out_word_next;

    side_t             sd;
    tanh_t             td;

    // pipe advances unless a finished word is held by the receiver
    assign ce       = ~(out_valid_reg & out_stall);
    assign in_stall = ~ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            func_reg <= FUNC_LINEAR;
        else if (function_select_we)
            func_reg <= function_select_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (ce)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_word_reg <= in_word;
            s1_func_reg <= func_reg;
        end
    end

    // magnitudes; sigmoid argument is the gate in gated mode, the value otherwise
    always_comb
    begin
        xe      = MAG_W'(s1_word_reg.value_in);
        ge      = MAG_W'(s1_word_reg.gate_in);
        mag_x   = s1_word_reg.value_in[DATA_WIDTH-1] ? MAG_W'(-xe) : xe;
        mag_g   = s1_word_reg.gate_in[DATA_WIDTH-1]  ? MAG_W'(-ge) : ge;
        if (s1_func_reg == FUNC_GATED)
        begin
            mag_sig = mag_g;
            sig_neg = s1_word_reg.gate_in[DATA_WIDTH-1];
        end
        else
        begin
            mag_sig = mag_x;
            sig_neg = s1_word_reg.value_in[DATA_WIDTH-1];
        end
    end

    nau_tanh_interp #(.SHIFT(FRAC_BITS - 2)) u_tanh_val (
        .clk (clk),
        .ce  (ce),
        .mag (mag_x),
        .y   (ya)
    );

    // sigmoid(x) = (1 + tanh(x/2)) / 2: halving the argument is one more shift
    nau_tanh_interp #(.SHIFT(FRAC_BITS - 1)) u_tanh_sig (
        .clk (clk),
        .ce  (ce),
        .mag (mag_sig),
        .y   (yb)
    );

    nau_softsign_div u_div_val (
        .clk  (clk),
        .ce   (ce),
        .mag  (mag_x),
        .quot (qx)
    );

    nau_softsign_div u_div_gate (
        .clk  (clk),
        .ce   (ce),
        .mag  (mag_g),
        .quot (qg)
    );

    always_comb
    begin
        side_next.func    = s1_func_reg;
        side_next.sx      = s1_word_reg.value_in[DATA_WIDTH-1];
        side_next.sg      = s1_word_reg.gate_in[DATA_WIDTH-1];
        side_next.sig_neg = sig_neg;
        side_next.mx      = mag_x;
        side_next.last    = s1_word_reg.last_in;
    end

    // side info rides alongside the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                side_valid_reg[i] <= 1'b0;
        end
        else if (ce)
        begin
            side_valid_reg[0] <= s1_valid_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                side_valid_reg[i] <= side_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DIV_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // Q1.17 sigmoid from the Q1.16 tanh of the halved argument
    always_comb
    begin
        tdel_next.ya  = ya;
        if (side_reg[TANH_STAGES-1].sig_neg)
            tdel_next.sig = (SIG_W'(1) << 16) - SIG_W'(yb);
        else
            tdel_next.sig = (SIG_W'(1) << 16) + SIG_W'(yb);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tdel_reg[0] <= tdel_next;
            for (int i = 1; i < TDEL; i++)
                tdel_reg[i] <= tdel_reg[i-1];
        end
    end

    assign sd = side_reg[DIV_STAGES-1];
    assign td = tdel_reg[TDEL-1];

    // pick the magnitude and sign in its own fixed-point format
    always_comb
    begin
        case (func_t'(sd.func))
            FUNC_TANH:
            begin
                p_mag_next = PROD_W'(td.ya);
                p_neg_next = sd.sx;
            end
            FUNC_SIGMOID:
            begin
                p_mag_next = PROD_W'(td.sig);
                p_neg_next = 1'b0;
            end
            FUNC_RELU:
            begin
                p_mag_next = sd.sx ? '0 : PROD_W'(sd.mx);
                p_neg_next = 1'b0;
            end
            FUNC_SOFTSIGN:
            begin
                p_mag_next = PROD_W'(qx);
                p_neg_next = sd.sx;
            end
            FUNC_GATED:
            begin
                p_mag_next = PROD_W'(td.ya) * PROD_W'(td.sig);
                p_neg_next = sd.sx;
            end
            FUNC_SOFTGATED:
            begin
                p_mag_next = PROD_W'(qx) * PROD_W'(qg);
                p_neg_next = sd.sx ^ sd.sg;
            end
            default:
            begin
                p_mag_next = PROD_W'(sd.mx);
                p_neg_next = sd.sx;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (ce)
            p_valid_reg <= side_valid_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p_mag_reg  <= p_mag_next;
            p_neg_reg  <= p_neg_next;
            p_func_reg <= sd.func;
            p_last_reg <= sd.last;
        end
    end

    // round magnitude half up to FRAC_BITS, saturate, apply sign
    always_comb
    begin
        case (func_t'(p_func_reg))
            FUNC_TANH:
                r_mag = (p_mag_reg + (PROD_W'(1) << (SH_TANH - 1))) >> SH_TANH;
            FUNC_SIGMOID:
                r_mag = (p_mag_reg + (PROD_W'(1) << (SH_SIGMOID - 1))) >> SH_SIGMOID;
            FUNC_SOFTSIGN:
                r_mag = (p_mag_reg + (PROD_W'(1) << (SH_SOFTSIGN - 1))) >> SH_SOFTSIGN;
            FUNC_GATED:
                r_mag = (p_mag_reg + (PROD_W'(1) << (SH_GATED - 1))) >> SH_GATED;
            FUNC_SOFTGATED:
                r_mag = (p_mag_reg + (PROD_W'(1) << (SH_SOFTGATE - 1))) >> SH_SOFTGATE;
            default:
                r_mag = p_mag_reg;
        endcase

        if (p_neg_reg)
            r_lim = (r_mag > (PROD_W'(1) << (DATA_WIDTH - 1)))
                  ? (PROD_W'(1) << (DATA_WIDTH - 1)) : r_mag;
        else
            r_lim = (r_mag > ((PROD_W'(1) << (DATA_WIDTH - 1)) - PROD_W'(1)))
                  ? ((PROD_W'(1) << (DATA_WIDTH - 1)) - PROD_W'(1)) : r_mag;

        r_signed = p_neg_reg ? (DATA_WIDTH+1)'(-r_lim[DATA_WIDTH:0])
                             : r_lim[DATA_WIDTH:0];

        out_word_next.value_out = r_signed[DATA_WIDTH-1:0];
        out_word_next.last_out  = p_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ce)
            out_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for neural_activation_unit: a directed sweep through every function plus a random stream
// of words, scored against an in-bench model of the fixed-point math.
// Depends on nau_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_top;
    import nau_pkg::*;

    // Holds the expected words in order and scores each result against the oldest.
    class activation_scoreboard;
        func_t                        fsel;
        logic signed [DATA_WIDTH-1:0] want_value[$];
        logic                         want_last[$];
        int                           errors;
        int                           checked;

        function new();
            fsel    = FUNC_LINEAR;
            errors  = 0;
            checked = 0;
        endfunction

        // tanh magnitude at Q1.16 of |x|, where x carries (s + 2) fraction bits
        function automatic longint tanh_mag(longint m, int s);
            longint idx;
            longint frac;
            longint lo;
            longint hi;
            idx  = m >>> s;
            frac = m & ((64'sd1 <<< s) - 1);
            if (idx >= TBL_LAST)
                return 65536;
            lo = tanh_entry(idx);
            hi = tanh_entry(idx + 1);
            return lo + (((hi - lo) * frac) >>> s);
        endfunction

        // tanh(k/4) in Q1.16
        function automatic longint tanh_entry(longint k);
            longint t[0:32];
            t = '{0, 16051, 30285, 41625, 49912, 55593, 59320, 61694,
                  63179, 64096, 64659, 65003, 65212, 65339, 65417, 65464,
                  65492, 65509, 65520, 65526, 65530, 65532, 65534, 65535,
                  65535, 65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536};
            return t[k];
        endfunction

        function automatic longint tanh_signed(longint x, int s);
            longint y;
            y = tanh_mag(x < 0 ? -x : x, s);
            return x < 0 ? -y : y;
        endfunction

        function automatic longint softsign_q30(longint x);
            longint m;
            longint den;
            longint q;
            m   = x < 0 ? -x : x;
            den = (64'sd1 <<< FRAC_BITS) + m;
            q   = ((m <<< 30) + (den >>> 1)) / den;
            return x < 0 ? -q : q;
        endfunction

        // round |v| half up to FRAC_BITS, then saturate
        function automatic longint saturate_round(longint v, int from_bits);
            longint m;
            longint r;
            longint maxv;
            m    = v < 0 ? -v : v;
            maxv = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
            if (from_bits > FRAC_BITS)
                m = (m + (64'sd1 <<< (from_bits - FRAC_BITS - 1))) >>> (from_bits - FRAC_BITS);
            r = v < 0 ? -m : m;
            if (r > maxv)
                r = maxv;
            if (r < -maxv - 1)
                r = -maxv - 1;
            return r;
        endfunction

        function automatic longint activation(longint x, longint g);
            case (fsel)
                FUNC_TANH:      return saturate_round(tanh_signed(x, FRAC_BITS - 2), 16);
                FUNC_SIGMOID:   return saturate_round(65536 + tanh_signed(x, FRAC_BITS - 1), 17);
                FUNC_RELU:      return x < 0 ? 0 : x;
                FUNC_SOFTSIGN:  return saturate_round(softsign_q30(x), 30);
                FUNC_GATED:     return saturate_round(tanh_signed(x, FRAC_BITS - 2)
                                       * (65536 + tanh_signed(g, FRAC_BITS - 1)), 33);
                FUNC_SOFTGATED: return saturate_round(softsign_q30(x) * softsign_q30(g), 60);
                default:        return x;
            endcase
        endfunction

        function void note_input(nau_in_t w);
            longint r;
            r = activation(longint'(w.value_in), longint'(w.gate_in));
            want_value.push_back(r[DATA_WIDTH-1:0]);
            want_last.push_back(w.last_in);
        endfunction

        function void check_result(nau_out_t w);
            logic signed [DATA_WIDTH-1:0] v;
            logic                         l;
            if (want_value.size() == 0)
            begin
                $error("result with nothing pending: value_out %0d", w.value_out);
                errors++;
                return;
            end
            v = want_value.pop_front();
            l = want_last.pop_front();
            checked++;
            if (w.value_out !== v)
            begin
                $error("value_out expected %0d actual %0d", v, w.value_out);
                errors++;
            end
            if (w.last_out !== l)
            begin
                $error("last_out expected %0d actual %0d", l, w.last_out);
                errors++;
            end
        endfunction
    endclass

    localparam int  LATENCY     = 12;
    localparam int  RANDOM_WORDS = 1600;
    localparam longint CYCLE_LIMIT = 400000;

    logic     clk;
    logic     rst_n;
    logic     function_select_we;
    logic [2:0] function_select_data;
    logic     in_valid;
    logic     in_stall;
    nau_in_t  in_word;
    logic     out_valid;
    logic     out_stall;
    nau_out_t out_word;

    activation_scoreboard sb;
    longint   cycle_count;
    bit       hold_off;      // long receiver hold-off, set by the stimulus
    bit       rx_idle_on;    // random receiver stalls enabled
    bit       tx_idle_on;    // random sender gaps enabled
    int       modes_run;

    neural_activation_unit dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .function_select_we   (function_select_we),
        .function_select_data (function_select_data),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .in_word              (in_word),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .out_word             (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Receiver: per word it draws a random stall run while rx_idle_on is set; the hold-off
    // flag keeps the output stalled so the pipe fills and in_stall rises.
    initial
    begin
        int wait_cycles;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = rx_idle_on ? $urandom_range(0, 13) : 0;
            repeat (wait_cycles)
            begin
                out_stall <= 1'b1;
                @(posedge clk);
            end
            while (hold_off)
            begin
                out_stall <= 1'b1;
                @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // score at the accepting edge; out_stall is read as it stood before the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_word);
    end

    // offer one word, hold it until accepted
    task automatic send_word(input logic signed [DATA_WIDTH-1:0] v,
                             input logic signed [DATA_WIDTH-1:0] g,
                             input logic l);
        int gap;
        nau_in_t w;
        gap = tx_idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.value_in = v;
        w.gate_in  = g;
        w.last_in  = l;
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(w);
    endtask

    // wait for the pipe to drain, then write function_select
    task automatic set_function(input logic [2:0] f);
        in_valid <= 1'b0;
        while (sb.want_value.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
        function_select_we   <= 1'b1;
        function_select_data <= f;
        @(posedge clk);
        function_select_we   <= 1'b0;
        sb.fsel = func_t'(f);
        modes_run++;
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] rand_value();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 65535));          // full range
            1:       return $signed(16'($urandom_range(0, 4096))) - 16'sd2048;  // near zero
            2:       return $urandom_range(0, 1) ? 16'(16'sh7fff - $urandom_range(0, 40))
                                                 : 16'(16'sh8000 + $urandom_range(0, 40));
            default: return $signed(16'($urandom_range(0, 16384))) - 16'sd8192; // +-2.0
        endcase
    endfunction

    initial
    begin
        logic signed [DATA_WIDTH-1:0] edge_vals[8];
        int n;
        sb = new();
        rst_n                = 1'b0;
        function_select_we   = 1'b0;
        function_select_data = 3'd0;
        in_valid             = 1'b0;
        in_word              = '0;
        hold_off             = 1'b0;
        rx_idle_on           = 1'b0;
        tx_idle_on           = 1'b0;
        modes_run            = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes through the reset function (linear)
        edge_vals = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 16'sd1,
                      16'sd4096, -16'sd4096, 16'sd32000};
        foreach (edge_vals[i])
            send_word(edge_vals[i], edge_vals[7 - i], i[0]);
        // each function including unused code 7, a few edge points each
        for (int f = 0; f < 8; f++)
        begin
            set_function(f[2:0]);
            send_word(16'sh8000, 16'sh7fff, 1'b1);
            send_word(16'sh7fff, 16'sh8000, 1'b0);
        end

        // random: phases with randomly drawn codes, idling on in most of them
        n = 0;
        while (n < RANDOM_WORDS)
        begin
            set_function((modes_run % 3 == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(0, 6)));
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            repeat (100)
            begin
                send_word(rand_value(), rand_value(), 1'($urandom_range(0, 1)));
                n++;
            end
        end

        // back-pressure: receiver holds off while the sender keeps offering
        tx_idle_on = 1'b0;
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (50)
                send_word(rand_value(), rand_value(), 1'($urandom_range(0, 1)));
        join

        in_valid <= 1'b0;
        while (sb.want_value.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("checked %0d results over %0d function settings, with random idling",
                 sb.checked, modes_run);
        $display("and one long receiver hold-off.");
        if (sb.errors == 0 && sb.want_value.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- neural_activation_unit.f -----
sv/nau_pkg.sv
sv/nau_tanh_interp.sv
sv/nau_softsign_div.sv
sv/neural_activation_unit.sv
tb/tb_top.sv
